### rtl/core/mf3_pkg.sv
// Shared types, constants and the three-input sort for the 3x3 median filter.
// No dependencies; every other file of the filter uses this package.
`default_nettype none

package mf3_pkg;

   localparam int PIX_W           = 8;
   localparam int MAX_LINE_PIXELS = 2048;
   localparam int COL_W           = $clog2(MAX_LINE_PIXELS);
   localparam int ROW_LIMIT       = 2048;
   localparam int ROW_W           = $clog2(ROW_LIMIT);
   localparam int CFG_W           = 12;
   localparam int CSR_IDX_W       = 2;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1920);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1080);

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic emit;
      logic frame_start;
      logic line_end;
   } tag_type;

   typedef struct packed {
      pix_type          pix;
      logic [COL_W-1:0] col;
      tag_type          tag;
   } item_type;

   typedef struct packed {
      pix_type lo;
      pix_type md;
      pix_type hi;
   } trio_type;

   function automatic trio_type sort3(input pix_type a, input pix_type b, input pix_type c);
      pix_type  x;
      pix_type  y;
      pix_type  z;
      pix_type  t;
      trio_type r;
      x = a;
      y = b;
      z = c;
      if (x > y) begin
         t = x; x = y; y = t;
      end
      if (y > z) begin
         t = y; y = z; z = t;
      end
      if (x > y) begin
         t = x; x = y; y = t;
      end
      r.lo = x;
      r.md = y;
      r.hi = z;
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/median_filter_3x3_stream.sv
// 3x3 median filter over a raster-order pixel stream, top level.
// Depends on mf3_pkg, mf3_front, mf3_fifo and mf3_back.
//
// Takes one pixel word per clock and returns one result per clock in steady
// state while rsp_ready stays high; a pixel's result passes the queue, the
// line-store read stage, the window stage, two sort stages and the result
// register. A four-word queue separates input from the filter pipeline, so input
// keeps flowing for up to four words after the result side stalls. Results are given
// only where the whole window lies in the frame (column and row both at least 2).
// Line stores hold no reset value: the first two lines of the first frame after
// reset fill them. Write frame_width and frame_height only while the block is idle.
`default_nettype none

module median_filter_3x3_stream (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [mf3_pkg::PIX_W-1:0]     req_pixel_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [mf3_pkg::PIX_W-1:0]          rsp_median_pixel,
   output logic                               rsp_frame_start,
   output logic                               rsp_line_end,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mf3_pkg::CFG_W-1:0]     csr_data
);
   import mf3_pkg::*;

   logic     queue_full;
   logic     push_valid;
   item_type push_item;
   logic     head_valid;
   item_type head_item;
   logic     pop;

   mf3_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel_in (req_pixel_in),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .queue_full   (queue_full),
      .push_valid   (push_valid),
      .push_item    (push_item)
   );

   mf3_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   mf3_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_pixel (rsp_median_pixel),
      .rsp_frame_start  (rsp_frame_start),
      .rsp_line_end     (rsp_line_end)
   );

endmodule

`default_nettype wire

### rtl/core/mf3_front.sv
// Front end: configuration registers, column and row counters, word classification.
// Depends on mf3_pkg; feeds mf3_fifo.
`default_nettype none

module mf3_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [mf3_pkg::PIX_W-1:0]     req_pixel_in,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mf3_pkg::CFG_W-1:0]     csr_data,
   input  wire logic                          queue_full,
   output logic                               push_valid,
   output mf3_pkg::item_type                  push_item
);
   import mf3_pkg::*;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_last;
   logic [ROW_W-1:0] row_last;
   logic             last_col;
   logic             last_row;
   logic             accept;

   assign req_ready  = ~queue_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_valid & req_ready;
   assign push_valid = accept;

   always_comb begin
      if (width_ff == '0 || width_ff > CFG_W'(MAX_LINE_PIXELS)) begin
         col_last = COL_W'(MAX_LINE_PIXELS - 1);
      end else begin
         col_last = COL_W'(width_ff - CFG_W'(1));
      end
      if (height_ff == '0 || height_ff > CFG_W'(ROW_LIMIT)) begin
         row_last = ROW_W'(ROW_LIMIT - 1);
      end else begin
         row_last = ROW_W'(height_ff - CFG_W'(1));
      end
   end

   assign last_col = (col_ff >= col_last);
   assign last_row = (row_ff >= row_last);

   always_comb begin
      push_item.pix             = req_pixel_in;
      push_item.col             = col_ff;
      push_item.tag.emit        = (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
      push_item.tag.frame_start = (col_ff == COL_W'(2)) && (row_ff == ROW_W'(2));
      push_item.tag.line_end    = last_col;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_index == CSR_FRAME_WIDTH) begin
         width_in = csr_data;
      end
      if (csr_valid && csr_index == CSR_FRAME_HEIGHT) begin
         height_in = csr_data;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/mf3_fifo.sv
// Short word queue between the front end and the filter pipeline.
// Depends on mf3_pkg for the word type and depth.
`default_nettype none

module mf3_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire mf3_pkg::item_type push_item,
   output logic                   full,
   output logic                   head_valid,
   output mf3_pkg::item_type      head_item,
   input  wire logic              pop
);
   import mf3_pkg::*;

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### rtl/core/mf3_back.sv
// Filter pipeline: line stores, 3x3 window, sort network and result register.
// Depends on mf3_pkg; takes words from mf3_fifo.
`default_nettype none

module mf3_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      head_valid,
   input  wire mf3_pkg::item_type         head_item,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [mf3_pkg::PIX_W-1:0]      rsp_median_pixel,
   output logic                           rsp_frame_start,
   output logic                           rsp_line_end
);
   import mf3_pkg::*;

   pix_type          older_mem [MAX_LINE_PIXELS];
   pix_type          newer_mem [MAX_LINE_PIXELS];

   logic             adv;
   logic             b1_leave;

   logic             b1_valid_ff;
   item_type         b1_item_ff;
   pix_type          older_rd_ff;
   pix_type          newer_rd_ff;

   logic             fw_valid_ff;
   logic [COL_W-1:0] fw_addr_ff;
   pix_type          fw_older_ff;
   pix_type          fw_newer_ff;
   logic             fw_hit;
   pix_type          older_cur;
   pix_type          newer_cur;

   pix_type          win_ff [3][3];
   logic             w_valid_ff;
   tag_type          w_tag_ff;

   logic             s1_valid_ff;
   tag_type          s1_tag_ff;
   trio_type         s1_row_ff [3];
   trio_type         row_sort [3];

   logic             s2_valid_ff;
   tag_type          s2_tag_ff;
   pix_type          s2_a_ff;
   pix_type          s2_b_ff;
   pix_type          s2_c_ff;
   trio_type         lo_sort;
   trio_type         md_sort;
   trio_type         hi_sort;
   trio_type         fin_sort;

   logic             out_valid_ff;
   pix_type          out_med_ff;
   logic             out_fs_ff;
   logic             out_le_ff;

   assign adv      = ~out_valid_ff | rsp_ready;
   assign pop      = adv & head_valid;
   assign b1_leave = adv & b1_valid_ff;

   // forward the previous store write when it hit this word's column
   assign fw_hit    = fw_valid_ff && (fw_addr_ff == b1_item_ff.col);
   assign older_cur = fw_hit ? fw_older_ff : older_rd_ff;
   assign newer_cur = fw_hit ? fw_newer_ff : newer_rd_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         older_rd_ff <= older_mem[head_item.col];
      end
      if (b1_leave) begin
         older_mem[b1_item_ff.col] <= newer_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         newer_rd_ff <= newer_mem[head_item.col];
      end
      if (b1_leave) begin
         newer_mem[b1_item_ff.col] <= b1_item_ff.pix;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sort[r] = sort3(win_ff[r][0], win_ff[r][1], win_ff[r][2]);
      end
      lo_sort  = sort3(s1_row_ff[0].lo, s1_row_ff[1].lo, s1_row_ff[2].lo);
      md_sort  = sort3(s1_row_ff[0].md, s1_row_ff[1].md, s1_row_ff[2].md);
      hi_sort  = sort3(s1_row_ff[0].hi, s1_row_ff[1].hi, s1_row_ff[2].hi);
      fin_sort = sort3(s2_a_ff, s2_b_ff, s2_c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         fw_valid_ff  <= 1'b0;
         w_valid_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         if (b1_leave) begin
            fw_valid_ff <= 1'b1;
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= older_cur;
            win_ff[1][2] <= newer_cur;
            win_ff[2][2] <= b1_item_ff.pix;
         end
         if (adv) begin
            b1_valid_ff  <= head_valid;
            w_valid_ff   <= b1_valid_ff;
            s1_valid_ff  <= w_valid_ff;
            s2_valid_ff  <= s1_valid_ff;
            out_valid_ff <= s2_valid_ff & s2_tag_ff.emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_item_ff <= head_item;
      end
      if (b1_leave) begin
         fw_addr_ff  <= b1_item_ff.col;
         fw_older_ff <= newer_cur;
         fw_newer_ff <= b1_item_ff.pix;
      end
      if (adv) begin
         w_tag_ff  <= b1_item_ff.tag;
         s1_tag_ff <= w_tag_ff;
         for (int r = 0; r < 3; r++) begin
            s1_row_ff[r] <= row_sort[r];
         end
         s2_tag_ff  <= s1_tag_ff;
         s2_a_ff    <= lo_sort.hi;
         s2_b_ff    <= md_sort.md;
         s2_c_ff    <= hi_sort.lo;
         out_med_ff <= fin_sort.md;
         out_fs_ff  <= s2_tag_ff.frame_start;
         out_le_ff  <= s2_tag_ff.line_end;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_median_pixel = out_med_ff;
   assign rsp_frame_start  = out_fs_ff;
   assign rsp_line_end     = out_le_ff;

endmodule

`default_nettype wire

### rtl/core/mf3_checker.sv
// Port-level checks for the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg and median_filter_3x3_stream.
`default_nettype none

module mf3_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [mf3_pkg::PIX_W-1:0]     rsp_median_pixel,
   input wire logic                          rsp_frame_start,
   input wire logic                          rsp_line_end
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median_pixel)
         && $stable(rsp_frame_start) && $stable(rsp_line_end))
      else $error("stalled result word changed");

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // input backs up only after the result side stalled
   a_full_after_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("input stalled without a result stall");

endmodule

bind median_filter_3x3_stream mf3_checker u_mf3_checker (.*);

`default_nettype wire

### verif/median_check_pkg.sv
`timescale 1ns / 1ps
// Predictor and result checker for the 3x3 median filter testbench.
// Depends on mf3_pkg for the pixel type, register indexes and frame limits.

package median_check_pkg;

   import mf3_pkg::*;

   typedef struct packed {
      pix_type px;
      logic    frame_start;
      logic    line_end;
   } median_word_type;

   function automatic void sort_trio(input pix_type a, input pix_type b, input pix_type c,
                                     output pix_type lo, output pix_type md,
                                     output pix_type hi);
      pix_type ab_min;
      pix_type ab_max;
      ab_min = (a < b) ? a : b;
      ab_max = (a < b) ? b : a;
      lo = (ab_min < c) ? ab_min : c;
      hi = (ab_max > c) ? ab_max : c;
      md = (c < ab_min) ? ab_min : ((c > ab_max) ? ab_max : c);
   endfunction

   class median_predictor;
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      pix_type          two_up [MAX_LINE_PIXELS];
      pix_type          one_up [MAX_LINE_PIXELS];
      pix_type          win [3][3];
      int unsigned      col;
      int unsigned      row;
      median_word_type  medians_due [$];
      int unsigned      mismatches;

      function new();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         for (int i = 0; i < MAX_LINE_PIXELS; i++) begin
            two_up[i] = '0;
            one_up[i] = '0;
         end
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win[r][c] = '0;
            end
         end
         col        = 0;
         row        = 0;
         mismatches = 0;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0 || width_reg > MAX_LINE_PIXELS) return MAX_LINE_PIXELS;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg == 0 || height_reg > ROW_LIMIT) return ROW_LIMIT;
         return height_reg;
      endfunction

      function int unsigned pending();
         return medians_due.size();
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
         case (idx)
            CSR_FRAME_WIDTH:  width_reg = value;
            CSR_FRAME_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      function void take_pixel(input pix_type p);
         int unsigned     w_eff;
         int unsigned     h_eff;
         int unsigned     idx;
         pix_type         lo [3];
         pix_type         md [3];
         pix_type         hi [3];
         pix_type         spare0;
         pix_type         spare1;
         pix_type         max_of_lows;
         pix_type         mid_of_mids;
         pix_type         min_of_highs;
         pix_type         med;
         logic            last_col;
         median_word_type word;
         w_eff = eff_width();
         h_eff = eff_height();
         idx   = (col < MAX_LINE_PIXELS) ? col : 0;
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
         win[0][2]   = two_up[idx];
         win[1][2]   = one_up[idx];
         win[2][2]   = p;
         two_up[idx] = one_up[idx];
         one_up[idx] = p;
         for (int r = 0; r < 3; r++) begin
            sort_trio(win[r][0], win[r][1], win[r][2], lo[r], md[r], hi[r]);
         end
         sort_trio(lo[0], lo[1], lo[2], spare0, spare1, max_of_lows);
         sort_trio(md[0], md[1], md[2], spare0, mid_of_mids, spare1);
         sort_trio(hi[0], hi[1], hi[2], min_of_highs, spare0, spare1);
         sort_trio(max_of_lows, mid_of_mids, min_of_highs, spare0, med, spare1);
         last_col = (col >= w_eff - 1);
         if (col >= 2 && row >= 2) begin
            word.px          = med;
            word.frame_start = (col == 2 && row == 2);
            word.line_end    = last_col;
            medians_due.push_back(word);
         end
         if (last_col) begin
            col = 0;
            row = (row >= h_eff - 1) ? 0 : row + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      function void match_median(input pix_type got_px, input logic got_start,
                                 input logic got_end);
         median_word_type want;
         if (medians_due.size() == 0) begin
            $display("%0t: unexpected median px %0d start %0b end %0b",
                     $time, got_px, got_start, got_end);
            mismatches++;
            return;
         end
         want = medians_due.pop_front();
         if ({got_px, got_start, got_end} !== want) begin
            $display("%0t: expected px %0d start %0b end %0b, got px %0d start %0b end %0b",
                     $time, want.px, want.frame_start, want.line_end,
                     got_px, got_start, got_end);
            mismatches++;
         end
      endfunction
   endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for median_filter_3x3_stream: directed and random frames.
// Depends on mf3_pkg, median_check_pkg and the filter RTL.

module tb_top;

   import mf3_pkg::*;
   import median_check_pkg::*;

   localparam int RANDOM_PIXELS = 770;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int LINE_FILL     = 40;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   pix_type              req_pixel_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   pix_type              rsp_median_pixel;
   logic                 rsp_frame_start;
   logic                 rsp_line_end;
   logic                 csr_valid    = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index    = CSR_FRAME_WIDTH;
   logic [CFG_W-1:0]     csr_data     = '0;

   int unsigned     tx_idle_pct = 0;
   int unsigned     rx_idle_pct = 0;
   bit              hold_armed  = 1'b0;
   median_predictor medians     = new();

   pix_type warmup_px [22] = '{
      8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
      8'hFE,
      8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF,
      8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00,
      8'h0F, 8'hF0, 8'h7F
   };

   always #6 clock = ~clock;

   median_filter_3x3_stream u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_pixel (rsp_median_pixel),
      .rsp_frame_start  (rsp_frame_start),
      .rsp_line_end     (rsp_line_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      #(5_000_000);
      $display("median_filter_3x3_stream test failed");
      $finish;
   end

   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            medians.match_median(rsp_median_pixel, rsp_frame_start, rsp_line_end);
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_armed && rsp_valid) begin
            // hold off results so the input queue fills and backs up
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_pixel(input pix_type p);
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      medians.take_pixel(p);
   endtask

   task automatic feed_random(input int unsigned count);
      repeat (count) send_pixel(pix_type'($urandom_range(255)));
      req_valid <= 1'b0;
   endtask

   task automatic settle();
      while (medians.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      csr_valid <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data  <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      medians.write_reg(CSR_FRAME_WIDTH, w);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_data  <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      medians.write_reg(CSR_FRAME_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned      rnd_items;
      int unsigned      count;
      int unsigned      we;
      int unsigned      he;
      int unsigned      pick;
      logic [CFG_W-1:0] w_val;
      logic [CFG_W-1:0] h_val;
      bit               hold_done;
      rnd_items   = 0;
      hold_done   = 1'b0;
      tx_idle_pct = 15;
      rx_idle_pct = 71;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 22; i++) begin
         if (i == 6) begin
            // lower width mid-line
            req_valid <= 1'b0;
            settle();
            set_frame(12'd3, HEIGHT_RESET);
         end
         if (i == 19) begin
            // lower height mid-frame
            req_valid <= 1'b0;
            settle();
            set_frame(12'd3, 12'd3);
         end
         send_pixel(warmup_px[i]);
      end
      req_valid <= 1'b0;

      // fill both line stores over the columns that later frames use
      settle();
      set_frame(CFG_W'(LINE_FILL), 12'd3);
      hold_armed = 1'b1;
      feed_random(3 * LINE_FILL);

      settle();
      set_frame(12'd4095, 12'd3);
      feed_random(20);
      settle();
      set_frame(12'd0, 12'd0);
      feed_random(15);
      settle();
      set_frame(12'd1, 12'd2048);
      feed_random(50);
      settle();
      set_frame(12'd2048, 12'd1);
      feed_random(30);
      settle();
      set_frame(12'd2, 12'd2);
      feed_random(20);

      while (rnd_items < RANDOM_PIXELS) begin
         if (rnd_items < RANDOM_PIXELS / 3) begin
            tx_idle_pct = 15;
            rx_idle_pct = 71;
         end else if (rnd_items < 2 * RANDOM_PIXELS / 3) begin
            tx_idle_pct = 71;
            rx_idle_pct = 15;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            if (!hold_done) begin
               hold_armed = 1'b1;
               hold_done  = 1'b1;
            end
         end
         pick = $urandom_range(9);
         if (pick < 8) w_val = CFG_W'($urandom_range(3, 12));
         else if (pick == 8) w_val = CFG_W'($urandom_range(1, 2));
         else w_val = CFG_W'($urandom_range(4095));
         pick = $urandom_range(9);
         if (pick < 8) h_val = CFG_W'($urandom_range(3, 8));
         else if (pick == 8) h_val = CFG_W'($urandom_range(1, 2));
         else h_val = CFG_W'($urandom_range(4095));
         settle();
         set_frame(w_val, h_val);
         we = medians.eff_width();
         he = medians.eff_height();
         if (we <= 16 && he <= 16) begin
            count = we * he * $urandom_range(1, 3);
            if ($urandom_range(3) == 0) count += $urandom_range(we * he - 1);
         end else if (medians.col + 1 < LINE_FILL) begin
            // keep columns inside the filled part of the line stores
            count = $urandom_range(1, LINE_FILL - 1 - medians.col);
         end else begin
            count = 0;
         end
         if (count > RANDOM_PIXELS - rnd_items) count = RANDOM_PIXELS - rnd_items;
         feed_random(count);
         rnd_items += count;
      end

      settle();
      if (medians.mismatches == 0 && medians.pending() == 0) begin
         $display("median_filter_3x3_stream test passed");
      end else begin
         $display("median_filter_3x3_stream test failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/mf3_pkg.sv
rtl/core/mf3_front.sv
rtl/core/mf3_fifo.sv
rtl/core/mf3_back.sv
rtl/core/median_filter_3x3_stream.sv
rtl/core/mf3_checker.sv
verif/median_check_pkg.sv
verif/tb_top.sv
